// ===== rtl/epd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, register indexes and the microprogram of the encoder
// position PID drive.
// ----------------------------------------------------------------------------
package epd_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int PC_W        = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROP_GAIN   = 4'd0,
      REG_INTEG_GAIN  = 4'd1,
      REG_DERIV_GAIN  = 4'd2,
      REG_DEG_PER_CNT = 4'd3,
      REG_MAX_DRIVE   = 4'd4,
      REG_BOOST_THR   = 4'd5,
      REG_MIN_DRIVE   = 4'd6,
      REG_DEADBAND    = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [23:0] prop_gain;
      logic [23:0] integ_gain;
      logic [23:0] deriv_gain;
      logic [23:0] degrees_per_count;
      logic [22:0] max_drive;
      logic [22:0] boost_threshold;
      logic [22:0] min_drive;
      logic [22:0] deadband;
   } cfg_type;

   // operand load: multiplier a/b pair
   typedef enum logic [2:0] {
      LD_NONE,
      LD_DELTA,   // count delta, degrees_per_count
      LD_ERR,     // e[n],   A0
      LD_E1,      // e[n-1], A1
      LD_E2       // e[n-2], A2
   } ld_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_INIT,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SETPT,
      OP_STEP,
      OP_POS,
      OP_ERR,
      OP_EFFORT,
      OP_SHAPE,
      OP_FIRST
   } alu_op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_GOTO,
      JC_IDLE,
      JC_WAIT_OUT
   } jmp_cond_type;

   typedef struct packed {
      logic         req_ready;
      ld_sel_type   ld_sel;
      logic         mul_en;
      acc_op_type   acc_op;
      alu_op_type   alu_op;
      jmp_cond_type jmp_cond;
      logic [PC_W-1:0] jmp_target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic first;
      logic out_busy;
   } cond_type;

   localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] PC_FIRST = 4'd13;

   localparam ctl_type CTL_NOP = '{
      req_ready:  1'b0,
      ld_sel:     LD_NONE,
      mul_en:     1'b0,
      acc_op:     ACC_HOLD,
      alu_op:     OP_NONE,
      jmp_cond:   JC_NEXT,
      jmp_target: PC_IDLE
   };

   function automatic ctl_type ucode(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = CTL_NOP;
      case (pc)
         4'd0: begin
            w.req_ready  = 1'b1;
            w.jmp_cond   = JC_IDLE;
            w.jmp_target = PC_FIRST;
         end
         4'd1: begin
            w.ld_sel = LD_DELTA;
            w.alu_op = OP_SETPT;
         end
         4'd2: w.mul_en = 1'b1;
         4'd3: w.alu_op = OP_STEP;
         4'd4: w.alu_op = OP_POS;
         4'd5: w.alu_op = OP_ERR;
         4'd6: begin
            w.ld_sel = LD_ERR;
            w.acc_op = ACC_INIT;
         end
         4'd7: begin
            w.mul_en = 1'b1;
            w.ld_sel = LD_E1;
         end
         4'd8: begin
            w.mul_en = 1'b1;
            w.ld_sel = LD_E2;
            w.acc_op = ACC_ADD;
         end
         4'd9: begin
            w.mul_en = 1'b1;
            w.acc_op = ACC_ADD;
         end
         4'd10: w.acc_op = ACC_ADD;
         4'd11: w.alu_op = OP_EFFORT;
         4'd12: begin
            w.alu_op     = OP_SHAPE;
            w.jmp_cond   = JC_WAIT_OUT;
            w.jmp_target = PC_IDLE;
         end
         4'd13: begin
            w.alu_op     = OP_FIRST;
            w.jmp_cond   = JC_WAIT_OUT;
            w.jmp_target = PC_IDLE;
         end
         default: begin
            w.jmp_cond   = JC_GOTO;
            w.jmp_target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/epd_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_csr
// Configuration register file: gains, scale and drive shaping limits.
// ----------------------------------------------------------------------------
module epd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [epd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [23:0]                        csr_data,
   output epd_pkg::cfg_type                   cfg
);

   epd_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            epd_pkg::REG_PROP_GAIN:   cfg_in.prop_gain         = csr_data;
            epd_pkg::REG_INTEG_GAIN:  cfg_in.integ_gain        = csr_data;
            epd_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain        = csr_data;
            epd_pkg::REG_DEG_PER_CNT: cfg_in.degrees_per_count = csr_data;
            epd_pkg::REG_MAX_DRIVE:   cfg_in.max_drive         = csr_data[22:0];
            epd_pkg::REG_BOOST_THR:   cfg_in.boost_threshold   = csr_data[22:0];
            epd_pkg::REG_MIN_DRIVE:   cfg_in.min_drive         = csr_data[22:0];
            epd_pkg::REG_DEADBAND:    cfg_in.deadband          = csr_data[22:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain         <= 24'd9830;
         cfg_ff.integ_gain        <= 24'd0;
         cfg_ff.deriv_gain        <= 24'd0;
         cfg_ff.degrees_per_count <= 24'd5760;
         cfg_ff.max_drive         <= 23'd3276800;
         cfg_ff.boost_threshold   <= 23'd983040;
         cfg_ff.min_drive         <= 23'd1310720;
         cfg_ff.deadband          <= 23'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/epd_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_sequencer
// Step counter and microcode ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module epd_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  epd_pkg::cond_type  cond,
   output epd_pkg::ctl_type   ctl
);

   logic [epd_pkg::PC_W-1:0] pc_ff, pc_in;

   assign ctl = epd_pkg::ucode(pc_ff);

   always_comb begin
      case (ctl.jmp_cond)
         epd_pkg::JC_NEXT: pc_in = pc_ff + 1'b1;
         epd_pkg::JC_GOTO: pc_in = ctl.jmp_target;
         epd_pkg::JC_IDLE: begin
            if (!cond.req_valid)  pc_in = pc_ff;
            else if (cond.first)  pc_in = ctl.jmp_target;
            else                  pc_in = pc_ff + 1'b1;
         end
         epd_pkg::JC_WAIT_OUT: pc_in = cond.out_busy ? pc_ff : ctl.jmp_target;
         default: pc_in = epd_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= epd_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/epd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_datapath
// Operand registers, shared multiplier, accumulator, saturating ALU,
// controller state and the result register.
// ----------------------------------------------------------------------------
module epd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  epd_pkg::ctl_type   ctl,
   input  epd_pkg::cfg_type   cfg,
   output epd_pkg::cond_type  cond,
   input  logic               req_tvalid,
   input  logic [63:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [119:0]       rsp_tdata
);

   localparam logic signed [61:0] SAT_MAX = 62'sd2147483647;
   localparam logic signed [61:0] SAT_MIN = -62'sd2147483648;
   localparam logic signed [61:0] RND_HALF = 62'sd32768;

   function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX)      r = 32'sh7fffffff;
      else if (v < SAT_MIN) r = 32'sh80000000;
      else                  r = v[31:0];
      return r;
   endfunction

   logic [31:0]        count_ff, count_in;
   logic signed [31:0] sp_ff, sp_in;
   logic [31:0]        prev_count_ff, prev_count_in;
   logic               count_valid_ff, count_valid_in;
   logic signed [31:0] prev_sp_ff, prev_sp_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] step_ff, step_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] e1_ff, e1_in;
   logic signed [31:0] e2_ff, e2_in;
   logic signed [31:0] eff_ff, eff_in;
   logic signed [32:0] opa_ff, opa_in;
   logic signed [26:0] opb_ff, opb_in;
   logic signed [59:0] prod_ff, prod_in;
   logic signed [61:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               out_busy;
   logic [31:0]        delta;
   logic [25:0]        a0_mag;
   logic [25:0]        a1_mag;
   logic signed [33:0] e_x, mx, bt, mn, db, drive, drive_abs;

   assign req_accept = req_tvalid & ctl.req_ready;
   assign out_busy   = rsp_valid_ff & ~rsp_tready;
   assign delta      = count_ff - prev_count_ff;
   assign a0_mag     = 26'(cfg.prop_gain) + 26'(cfg.integ_gain) + 26'(cfg.deriv_gain);
   assign a1_mag     = 26'(cfg.prop_gain) + 26'({cfg.deriv_gain, 1'b0});

   assign cond.req_valid = req_tvalid;
   assign cond.first     = ~count_valid_ff;
   assign cond.out_busy  = out_busy;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // drive shaping
   always_comb begin
      e_x = 34'(eff_ff);
      mx  = signed'({11'd0, cfg.max_drive});
      bt  = signed'({11'd0, cfg.boost_threshold});
      mn  = signed'({11'd0, cfg.min_drive});
      db  = signed'({11'd0, cfg.deadband});
      if (e_x > mx)       drive = mx;
      else if (e_x < -mx) drive = -mx;
      else                drive = e_x;
      if (e_x < bt && e_x > db)        drive = mn;
      else if (e_x > -bt && e_x < -db) drive = -mn;
      if (e_x < db && e_x > -db)       drive = '0;
      drive_abs = drive[33] ? -drive : drive;
   end

   always_comb begin
      count_in       = count_ff;
      sp_in          = sp_ff;
      prev_count_in  = prev_count_ff;
      count_valid_in = count_valid_ff;
      prev_sp_in     = prev_sp_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      err_in         = err_ff;
      e1_in          = e1_ff;
      e2_in          = e2_ff;
      eff_in         = eff_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      if (req_accept) begin
         count_in = req_tdata[31:0];
         sp_in    = signed'(req_tdata[63:32]);
      end

      case (ctl.ld_sel)
         epd_pkg::LD_DELTA: begin
            opa_in = 33'(signed'(delta));
            opb_in = signed'({3'd0, cfg.degrees_per_count});
         end
         epd_pkg::LD_ERR: begin
            opa_in = 33'(err_ff);
            opb_in = signed'({1'b0, a0_mag});
         end
         epd_pkg::LD_E1: begin
            opa_in = 33'(e1_ff);
            opb_in = -signed'({1'b0, a1_mag});
         end
         epd_pkg::LD_E2: begin
            opa_in = 33'(e2_ff);
            opb_in = signed'({3'd0, cfg.deriv_gain});
         end
         default: ;
      endcase

      if (ctl.mul_en) prod_in = opa_ff * opb_ff;

      case (ctl.acc_op)
         epd_pkg::ACC_INIT: acc_in = RND_HALF;
         epd_pkg::ACC_ADD:  acc_in = acc_ff + 62'(prod_ff);
         default: ;
      endcase

      case (ctl.alu_op)
         epd_pkg::OP_SETPT: begin
            prev_count_in = count_ff;
            if (sp_ff != prev_sp_ff) begin
               pos_in     = '0;
               prev_sp_in = sp_ff;
            end
         end
         epd_pkg::OP_STEP: step_in = sat32(62'(prod_ff));
         epd_pkg::OP_POS:  pos_in  = sat32(62'(pos_ff) + 62'(step_ff));
         epd_pkg::OP_ERR:  err_in  = sat32(62'(sp_ff) - 62'(pos_ff));
         epd_pkg::OP_EFFORT: begin
            eff_in = sat32((acc_ff >>> 16) + 62'(eff_ff));
            e2_in  = e1_ff;
            e1_in  = err_ff;
         end
         epd_pkg::OP_SHAPE: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {eff_ff, step_ff, pos_ff, ~drive[33], drive_abs[22:0]};
            end
         end
         epd_pkg::OP_FIRST: begin
            if (!out_busy) begin
               prev_count_in  = count_ff;
               count_valid_in = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = {32'd0, 32'd0, pos_ff, 1'b1, 23'd0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff  <= '0;
         count_valid_ff <= 1'b0;
         prev_sp_ff     <= '0;
         pos_ff         <= '0;
         e1_ff          <= '0;
         e2_ff          <= '0;
         eff_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_count_ff  <= prev_count_in;
         count_valid_ff <= count_valid_in;
         prev_sp_ff     <= prev_sp_in;
         pos_ff         <= pos_in;
         e1_ff          <= e1_in;
         e2_ff          <= e2_in;
         eff_ff         <= eff_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      sp_ff       <= sp_in;
      step_ff     <= step_in;
      err_ff      <= err_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/encoder_position_pid_drive_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_pid_drive_unit
// Encoder position estimate, incremental PID and drive shaping per tick.
// ----------------------------------------------------------------------------
// One word on req is one control tick. A normal tick runs the 13 steps of the
// microprogram from acceptance to the result word loading rsp; they put the
// position scaling and the three PID products through one shared 33x27
// multiplier, and the PID products through the accumulator. The next word can
// be taken at the earliest in the cycle after that. The very first tick after
// reset only captures the counter, in a step of its own. A result left waiting
// on rsp holds the final step until it is taken; the next tick may already be
// computing meanwhile. Configuration writes are accepted in any cycle and
// should be issued while the block is idle.
module encoder_position_pid_drive_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] encoder_count, [63:32] setpoint
   input  logic [63:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [22:0] drive_magnitude, [23] drive_forward, [55:24] position,
   // [87:56] position_step, [119:88] effort
   output logic [119:0]                     rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [epd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [23:0]                      csr_data
);

   epd_pkg::cfg_type  cfg;
   epd_pkg::ctl_type  ctl;
   epd_pkg::cond_type cond;

   assign req_tready = ctl.req_ready;

   epd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   epd_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl)
   );

   epd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cfg        (cfg),
      .cond       (cond),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // one tick at a time: no second word right behind an accepted one
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted in consecutive cycles");

   // reverse drive always carries a nonzero magnitude
   a_reverse_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[23] |-> rsp_tdata[22:0] != 23'd0)
      else $error("reverse drive with zero magnitude");

   // nothing pending on rsp right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // no new tick starts while the sequencer is busy with the output step
   a_ready_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !req_tready |=> !(req_tvalid && req_tready)
         || !rsp_tvalid || rsp_tready)
      else $error("tick accepted during output stall");

endmodule
